@@ hdl/rtc_cal_pkg.sv @@
// Shared types, constants and helper functions for the RTC calendar set/adjust block.
// No dependencies.
package rtc_cal_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_ADJUST = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        field_second;
      logic [7:0]        field_minute;
      logic [7:0]        field_hour;
      logic [7:0]        field_weekday;
      logic [7:0]        field_date;
      logic [7:0]        field_month;
      logic [7:0]        field_year;
      logic signed [7:0] delta_hours;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       rtc_write;
      logic       time_valid;
      logic [6:0] bcd_second;
      logic [6:0] bcd_minute;
      logic [5:0] bcd_hour;
      logic [2:0] weekday_out;
      logic [5:0] bcd_date;
      logic [4:0] bcd_month;
      logic [7:0] bcd_year;
   } rsp_type;

   function automatic logic [6:0] from_bcd(input logic [7:0] v);
      logic [6:0] hi;
      logic [6:0] lo;
      hi = {3'd0, v[7:4]};
      lo = {3'd0, v[3:0]};
      return 7'((hi << 3) + (hi << 1) + lo);
   endfunction

   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [10:0] p;
      logic [3:0]  t;
      logic [6:0]  tens;
      logic [6:0]  lo;
      p    = {4'd0, v} * 11'd13;
      t    = p[10:7];
      tens = {3'd0, t} * 7'd10;
      if (tens > v) begin
         t    = t - 4'd1;
         tens = tens - 7'd10;
      end
      if (v - tens > 7'd9) begin
         t    = t + 4'd1;
         tens = tens + 7'd10;
      end
      lo = v - tens;
      return {t, lo[3:0]};
   endfunction

   function automatic logic [4:0] month_len(input logic [6:0] yr, input logic [3:0] mo);
      logic [4:0] r;
      case (mo)
         4'd2:                      r = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
         default:                   r = 5'd31;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] sak(input logic [3:0] mo);
      logic [2:0] r;
      case (mo)
         4'd1: r = 3'd0;  4'd2: r = 3'd3;  4'd3: r = 3'd2;  4'd4: r = 3'd5;
         4'd5: r = 3'd0;  4'd6: r = 3'd3;  4'd7: r = 3'd5;  4'd8: r = 3'd1;
         4'd9: r = 3'd4;  4'd10: r = 3'd6; 4'd11: r = 3'd2; 4'd12: r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/rtc_cal_step.sv @@
// Step unit: moves a date one day forward or back, with month and year carry.
// Depends on rtc_cal_pkg.
module rtc_cal_step
   import rtc_cal_pkg::*;
(
   input  logic        up,
   input  logic [7:0]  year_in,
   input  logic [3:0]  month_in,
   input  logic [4:0]  date_in,
   output logic [7:0]  year_out,
   output logic [3:0]  month_out,
   output logic [4:0]  date_out
);
   logic [3:0] pm;
   logic [7:0] py;
   always_comb begin
      year_out  = year_in;
      month_out = month_in;
      date_out  = date_in;
      pm = (month_in == 4'd1) ? 4'd12 : month_in - 4'd1;
      py = (month_in == 4'd1) ? year_in - 8'd1 : year_in;
      if (up) begin
         if (date_in >= month_len(year_in[6:0], month_in)) begin
            date_out = 5'd1;
            if (month_in == 4'd12) begin
               month_out = 4'd1;
               year_out  = year_in + 8'd1;
            end else begin
               month_out = month_in + 4'd1;
            end
         end else begin
            date_out = date_in + 5'd1;
         end
      end else begin
         if (date_in <= 5'd1) begin
            month_out = pm;
            year_out  = py;
            date_out  = month_len(py[6:0], pm);
         end else begin
            date_out = date_in - 5'd1;
         end
      end
   end
endmodule

@@ hdl/rtc_calendar_set_adjust.sv @@
// RTC calendar keeper, years 2000-2099: load, set and adjust commands.
// One beat in, one beat out, one command at a time; req_ready is high only when idle.
// Load, a zero adjust and any rejected command answer the cycle after acceptance.
// Set forms the weekday sum in S_WD1, then reduces it mod 7 in S_WD2 (subtracting 56,
// 14 or 7 at each step) before its result is presented from S_OUT.
// Adjust first carries a loaded date beyond month length into the next month (S_NORM),
// then steps one day per day of offset (at most 6) through the carry unit (S_DAYS),
// then forms the weekday; out of century it answers after the day steps. The input
// is ready again the cycle after the result beat is taken.
// Depends on rtc_cal_pkg and rtc_cal_step.
module rtc_calendar_set_adjust
   import rtc_cal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_NORM = 6'b000010, S_DAYS = 6'b000100,
      S_WD1  = 6'b001000, S_WD2  = 6'b010000, S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] sec_ff, sec_in, min_ff, min_in;
   logic [4:0] hour_ff, hour_in, date_ff, date_in;
   logic [2:0] wd_ff, wd_in;
   logic [3:0] mon_ff, mon_in;
   logic [6:0] year_ff, year_in;
   logic       rdy_ff, rdy_in;
   // working copies
   logic [7:0] wy_ff, wy_in;
   logic [3:0] wm_ff, wm_in;
   logic [4:0] wd5_ff, wd5_in;
   logic [5:0] wmin_ff, wmin_in;
   logic [5:0] wsec_ff, wsec_in;
   logic [3:0] days_ff, days_in;
   logic       up_ff, up_in;
   logic [8:0] acc_ff, acc_in;
   logic [1:0] st_ff, st_in;
   logic       wr_ff, wr_in;
   logic       vout_ff, vout_in;

   logic [7:0] sy;
   logic [3:0] sm;
   logic [4:0] sd;
   rtc_cal_step u_step (
      .up(up_ff), .year_in(wy_ff), .month_in(wm_ff), .date_in(wd5_ff),
      .year_out(sy), .month_out(sm), .date_out(sd)
   );

   logic [6:0] l_s, l_mi, l_h12, l_h, l_d, l_mo, l_y;
   logic [2:0] l_wd;
   logic       l_ok, s_ok;
   logic [9:0] hsum;
   logic [6:0] yq;
   logic [8:0] wsum;
   logic [8:0] wsub;
   logic [9:0] hs10;

   always_comb begin
      l_s   = from_bcd({1'b0, req_data.field_second[6:0]});
      l_mi  = from_bcd({1'b0, req_data.field_minute[6:0]});
      l_h12 = from_bcd({3'd0, req_data.field_hour[4:0]});
      if (req_data.field_hour[6]) begin
         if (l_h12 == 7'd12) l_h = req_data.field_hour[5] ? 7'd12 : 7'd0;
         else l_h = l_h12 + (req_data.field_hour[5] ? 7'd12 : 7'd0);
      end else begin
         l_h = from_bcd({2'd0, req_data.field_hour[5:0]});
      end
      l_wd = req_data.field_weekday[2:0];
      l_d  = from_bcd({2'd0, req_data.field_date[5:0]});
      l_mo = from_bcd({3'd0, req_data.field_month[4:0]});
      l_y  = from_bcd(req_data.field_year);
      l_ok = (l_h <= 7'd23) && (l_mi <= 7'd59) && (l_s <= 7'd59) && (l_d >= 7'd1)
         && (l_d <= 7'd31) && (l_mo >= 7'd1) && (l_mo <= 7'd12) && (l_wd != 3'd0)
         && (l_y <= 7'd99) && (req_data.field_year[7:4] <= 4'd9);
      s_ok = (req_data.field_hour <= 8'd23) && (req_data.field_minute <= 8'd59)
         && (req_data.field_second <= 8'd59) && (req_data.field_month >= 8'd1)
         && (req_data.field_month <= 8'd12) && (req_data.field_date >= 8'd1)
         && (req_data.field_date <= {3'd0, month_len(req_data.field_year[6:0],
                                                      req_data.field_month[3:0])});
      hsum = 10'({{5{1'b0}}, hour_ff}) + 10'($signed(req_data.delta_hours));
      hs10 = hsum;
      // Sakamoto in years 1999..2099
      yq = 7'(wy_ff) - ((wm_ff < 4'd3) ? 7'd1 : 7'd0);
      wsum = (yq == 7'h7F) ? 9'd5 + 9'(sak(wm_ff)) + 9'(wd5_ff)
           : 9'(yq) + 9'(yq >> 2) + 9'(sak(wm_ff)) + 9'(wd5_ff);
      wsub = (acc_ff >= 9'd56) ? 9'd56 : ((acc_ff >= 9'd14) ? 9'd14 : 9'd7);
   end

   logic signed [9:0] h_s;
   logic [3:0]        dcount;
   logic              dneg;
   logic [4:0]        adj_hour;
   always_comb begin
      // Day offset of the hour shift: floor(hsum/24), |offset| <= 6
      h_s      = $signed(hs10);
      dneg     = h_s < 0;
      dcount   = 4'd0;
      adj_hour = 5'd0;
      for (int k = 6; k >= 1; k--) begin
         if (!dneg && h_s >= 10'(24 * k) && dcount == 4'd0) begin
            dcount   = 4'(k);
            adj_hour = 5'(h_s - 10'(24 * k));
         end
         if (dneg && h_s >= -10'(24 * k) && h_s < -10'(24 * (k - 1))) begin
            dcount   = 4'(k);
            adj_hour = 5'(h_s + 10'(24 * k));
         end
      end
      if (!dneg && dcount == 4'd0) adj_hour = 5'(h_s);
   end

   always_comb begin
      state_in = state_ff;
      sec_in = sec_ff; min_in = min_ff; hour_in = hour_ff; date_in = date_ff;
      wd_in = wd_ff; mon_in = mon_ff; year_in = year_ff; rdy_in = rdy_ff;
      wy_in = wy_ff; wm_in = wm_ff; wd5_in = wd5_ff; wmin_in = wmin_ff;
      wsec_in = wsec_ff; days_in = days_ff; up_in = up_ff; acc_in = acc_ff;
      st_in = st_ff; wr_in = wr_ff; vout_in = vout_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               st_in = ST_OK; wr_in = 1'b0; state_in = S_OUT; vout_in = 1'b1;
               case (req_data.command)
                  CMD_LOAD: begin
                     if (l_ok) begin
                        sec_in = l_s[5:0]; min_in = l_mi[5:0]; hour_in = l_h[4:0];
                        wd_in = l_wd; date_in = l_d[4:0]; mon_in = l_mo[3:0];
                        year_in = l_y; rdy_in = 1'b1;
                     end else st_in = ST_BAD;
                  end
                  CMD_SET: begin
                     if (req_data.field_year > 8'd99) st_in = ST_RANGE;
                     else if (!s_ok) st_in = ST_BAD;
                     else begin
                        wy_in = req_data.field_year; wm_in = req_data.field_month[3:0];
                        wd5_in = req_data.field_date[4:0];
                        wmin_in = req_data.field_minute[5:0];
                        wsec_in = req_data.field_second[5:0];
                        acc_in = {4'd0, req_data.field_hour[4:0]};
                        vout_in = 1'b0; state_in = S_WD1;
                     end
                  end
                  CMD_ADJUST: begin
                     if (req_data.delta_hours != 8'sd0) begin
                        wy_in = {1'b0, year_ff}; wm_in = mon_ff; wd5_in = date_ff;
                        wmin_in = min_ff; wsec_in = sec_ff;
                        acc_in = {4'd0, adj_hour}; days_in = dcount; up_in = !dneg;
                        vout_in = 1'b0; state_in = S_NORM;
                     end
                  end
                  default: st_in = ST_BAD;
               endcase
            end
         end
         S_NORM: begin
            // carry a loaded date beyond month length into the next month
            if (wd5_ff > month_len(wy_ff[6:0], wm_ff)) begin
               wd5_in = wd5_ff - month_len(wy_ff[6:0], wm_ff);
               if (wm_ff == 4'd12) begin wm_in = 4'd1; wy_in = wy_ff + 8'd1; end
               else wm_in = wm_ff + 4'd1;
            end else state_in = S_DAYS;
         end
         S_DAYS: begin
            if (days_ff != 4'd0) begin
               wy_in = sy; wm_in = sm; wd5_in = sd; days_in = days_ff - 4'd1;
            end else if (wy_ff > 8'd99) begin
               st_in = ST_RANGE; vout_in = 1'b1; state_in = S_OUT;
            end else state_in = S_WD1;
         end
         S_WD1: begin
            hour_in = acc_ff[4:0];
            acc_in = wsum;
            state_in = S_WD2;
         end
         S_WD2: begin
            if (acc_ff >= 9'd7) acc_in = acc_ff - wsub;
            else begin
               wd_in = 3'(acc_ff) + 3'd1;
               sec_in = wsec_ff; min_in = wmin_ff; date_in = wd5_ff;
               mon_in = wm_ff; year_in = wy_ff[6:0]; rdy_in = 1'b1;
               wr_in = 1'b1; st_in = ST_OK; vout_in = 1'b1; state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin vout_in = 1'b0; state_in = S_IDLE; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sec_ff <= '0; min_ff <= '0; hour_ff <= '0; wd_ff <= 3'd7;
         date_ff <= 5'd1; mon_ff <= 4'd1; year_ff <= '0; rdy_ff <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sec_ff <= sec_in; min_ff <= min_in; hour_ff <= hour_in; wd_ff <= wd_in;
         date_ff <= date_in; mon_ff <= mon_in; year_ff <= year_in; rdy_ff <= rdy_in;
         vout_ff <= vout_in;
      end
      wy_ff <= wy_in; wm_ff <= wm_in; wd5_ff <= wd5_in;
      wmin_ff <= wmin_in; wsec_ff <= wsec_in; days_ff <= days_in; up_ff <= up_in;
      acc_ff <= acc_in; st_ff <= st_in; wr_ff <= wr_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = vout_ff;

   logic [7:0] b_sec, b_min, b_hour, b_date, b_mon, b_year;
   always_comb begin
      b_sec  = to_bcd({1'b0, sec_ff});
      b_min  = to_bcd({1'b0, min_ff});
      b_hour = to_bcd({2'd0, hour_ff});
      b_date = to_bcd({2'd0, date_ff});
      b_mon  = to_bcd({3'd0, mon_ff});
      b_year = to_bcd(year_ff);
      rsp_data.status      = st_ff;
      rsp_data.rtc_write   = wr_ff;
      rsp_data.time_valid  = rdy_ff;
      rsp_data.bcd_second  = b_sec[6:0];
      rsp_data.bcd_minute  = b_min[6:0];
      rsp_data.bcd_hour    = b_hour[5:0];
      rsp_data.weekday_out = wd_ff;
      rsp_data.bcd_date    = b_date[5:0];
      rsp_data.bcd_month   = b_mon[4:0];
      rsp_data.bcd_year    = b_year;
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rtc_write) |-> (rsp_data.status == ST_OK))
      else $error("write strobe with error status");
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rtc_write) |-> rsp_data.time_valid)
      else $error("write without valid time");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped");
`endif
endmodule

@@ bench/tb_rtc_calendar_set_adjust.sv @@
// Testbench for rtc_calendar_set_adjust: load, set and adjust commands checked against
// a behavioural calendar model kept in the bench, with random gaps and a long hold-off.
// Depends on rtc_cal_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_rtc_calendar_set_adjust;
   import rtc_cal_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rtc_calendar_set_adjust dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   int cal_sec, cal_min, cal_hour, cal_wday, cal_date, cal_month, cal_year;
   bit cal_ready;

   rsp_type expected_times[$];
   int      error_count;
   int      beats_sent;
   int      beats_seen;
   int      cycle_count;
   bit      hold_off;
   int      hold_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int bcd_value(input int v);
      return ((v >> 4) & 15) * 10 + (v & 15);
   endfunction

   function automatic int bcd_pack(input int v);
      return ((v / 10) << 4) | (v % 10);
   endfunction

   function automatic int days_in(input int yr, input int mo);
      int full;
      full = 2000 + yr;
      if (mo == 2) begin
         return (((full % 4) == 0 && (full % 100) != 0) || (full % 400) == 0) ? 29 : 28;
      end
      if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
      return 31;
   endfunction

   function automatic int day_of_week(input int yr, input int mo, input int d);
      int y;
      int tab[12];
      tab = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      y = 2000 + yr;
      if (mo < 3) y--;
      return ((y + y / 4 - y / 100 + y / 400 + tab[(mo - 1) % 12] + d) % 7) + 1;
   endfunction

   function automatic void commit_time(input int h, input int mi, input int s,
                                       input int d, input int mo, input int y);
      cal_hour = h; cal_min = mi; cal_sec = s;
      cal_date = d; cal_month = mo; cal_year = y;
      cal_wday = day_of_week(y, mo, d);
      cal_ready = 1'b1;
   endfunction

   function automatic rsp_type predict_time(input req_type r);
      rsp_type o;
      int s, mi, h, h12, wd, d, mo, y, delta, total, off, yy;
      logic [1:0] st;
      bit wr;
      st = ST_OK;
      wr = 1'b0;
      case (r.command)
         CMD_LOAD: begin
            s  = bcd_value(r.field_second & 8'h7F);
            mi = bcd_value(r.field_minute & 8'h7F);
            if (r.field_hour[6]) begin
               h12 = bcd_value(r.field_hour & 8'h1F);
               if (h12 == 12) h = r.field_hour[5] ? 12 : 0;
               else h = h12 + (r.field_hour[5] ? 12 : 0);
            end else begin
               h = bcd_value(r.field_hour & 8'h3F);
            end
            wd = r.field_weekday & 7;
            d  = bcd_value(r.field_date & 8'h3F);
            mo = bcd_value(r.field_month & 8'h1F);
            y  = bcd_value(r.field_year);
            if (h > 23 || mi > 59 || s > 59 || d < 1 || d > 31 || mo < 1 || mo > 12 ||
                wd < 1 || y > 99) begin
               st = ST_BAD;
            end else begin
               cal_sec = s; cal_min = mi; cal_hour = h; cal_wday = wd;
               cal_date = d; cal_month = mo; cal_year = y; cal_ready = 1'b1;
            end
         end
         CMD_SET: begin
            s = r.field_second; mi = r.field_minute; h = r.field_hour;
            d = r.field_date; mo = r.field_month; y = r.field_year;
            if (y > 99) st = ST_RANGE;
            else if (h > 23 || mi > 59 || s > 59 || mo < 1 || mo > 12 || d < 1 ||
                     d > days_in(y, mo)) st = ST_BAD;
            else begin
               commit_time(h, mi, s, d, mo, y);
               wr = 1'b1;
            end
         end
         CMD_ADJUST: begin
            delta = int'(r.delta_hours);
            if (delta != 0) begin
               total = cal_hour * 60 + cal_min + delta * 60;
               off = 0;
               while (total < 0) begin total += 1440; off--; end
               while (total >= 1440) begin total -= 1440; off++; end
               y = 2000 + cal_year; mo = cal_month; d = cal_date + off;
               while (d < 1) begin
                  mo--;
                  if (mo < 1) begin mo = 12; y--; end
                  yy = (y >= 2000 && y <= 2099) ? y - 2000 : 0;
                  d += days_in(yy, mo);
               end
               forever begin
                  yy = (y >= 2000 && y <= 2099) ? y - 2000 : 0;
                  if (d <= days_in(yy, mo)) break;
                  d -= days_in(yy, mo);
                  mo++;
                  if (mo > 12) begin mo = 1; y++; end
               end
               if (y < 2000 || y > 2099) st = ST_RANGE;
               else begin
                  commit_time(total / 60, total % 60, cal_sec, d, mo, y - 2000);
                  wr = 1'b1;
               end
            end
         end
         default: st = ST_BAD;
      endcase
      o.status      = st;
      o.rtc_write   = wr;
      o.time_valid  = cal_ready;
      o.bcd_second  = 7'(bcd_pack(cal_sec));
      o.bcd_minute  = 7'(bcd_pack(cal_min));
      o.bcd_hour    = 6'(bcd_pack(cal_hour));
      o.weekday_out = 3'(cal_wday);
      o.bcd_date    = 6'(bcd_pack(cal_date));
      o.bcd_month   = 5'(bcd_pack(cal_month));
      o.bcd_year    = 8'(bcd_pack(cal_year));
      return o;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   task automatic send_beat(input req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_times.push_back(predict_time(r));
      beats_sent++;
   endtask

   function automatic req_type blank_req(input logic [1:0] cmd);
      req_type r;
      r = '0;
      r.command = cmd;
      return r;
   endfunction

   function automatic req_type set_req(input int h, input int mi, input int s,
                                       input int d, input int mo, input int y);
      req_type r;
      r = blank_req(CMD_SET);
      r.field_hour = 8'(h); r.field_minute = 8'(mi); r.field_second = 8'(s);
      r.field_date = 8'(d); r.field_month = 8'(mo); r.field_year = 8'(y);
      r.field_weekday = 8'($urandom);
      return r;
   endfunction

   function automatic req_type adjust_req(input int delta);
      req_type r;
      r = blank_req(CMD_ADJUST);
      r.delta_hours = 8'(delta);
      return r;
   endfunction

   function automatic req_type load_req(input int h, input int mi, input int s, input int wd,
                                        input int d, input int mo, input int y);
      req_type r;
      r = blank_req(CMD_LOAD);
      r.field_hour = 8'(h); r.field_minute = 8'(mi); r.field_second = 8'(s);
      r.field_weekday = 8'(wd); r.field_date = 8'(d); r.field_month = 8'(mo);
      r.field_year = 8'(y);
      return r;
   endfunction

   task automatic test_directed_commands();
      send_beat(adjust_req(0));
      send_beat(blank_req(2'd3));
      send_beat(load_req(8'h23, 8'h59, 8'h59, 7, 8'h31, 8'h12, 8'h99));
      send_beat(load_req(8'h72, 8'h00, 8'h00, 1, 8'h01, 8'h81, 8'h00));
      send_beat(load_req(8'h52, 8'h30, 8'h15, 3, 8'h15, 8'h06, 8'h24));
      send_beat(load_req(8'h6B, 8'h00, 8'h00, 3, 8'h15, 8'h06, 8'h24));
      send_beat(load_req(8'h24, 8'h00, 8'h00, 3, 8'h15, 8'h06, 8'h24));
      send_beat(load_req(8'h10, 8'h00, 8'h00, 0, 8'h15, 8'h06, 8'hA0));
      send_beat(load_req(8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_beat(load_req(8'h23, 8'h00, 8'h00, 2, 8'h31, 8'h02, 8'h23));
      send_beat(adjust_req(1));
      send_beat(set_req(12, 0, 0, 29, 2, 0));
      send_beat(set_req(12, 0, 0, 29, 2, 1));
      send_beat(set_req(0, 0, 0, 1, 1, 100));
      send_beat(set_req(255, 255, 255, 255, 255, 255));
      send_beat(set_req(0, 0, 0, 0, 0, 0));
      send_beat(set_req(23, 59, 59, 31, 12, 99));
      send_beat(adjust_req(127));
      send_beat(adjust_req(1));
      send_beat(set_req(0, 0, 0, 1, 1, 0));
      send_beat(adjust_req(-1));
      send_beat(adjust_req(-128));
      send_beat(adjust_req(127));
   endtask

   task automatic test_random_commands(input int count);
      req_type r;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               r = load_req(bcd_pack($urandom_range(0, 23)), bcd_pack($urandom_range(0, 59)),
                            bcd_pack($urandom_range(0, 59)), $urandom_range(1, 7),
                            bcd_pack($urandom_range(1, 31)), bcd_pack($urandom_range(1, 12)),
                            bcd_pack($urandom_range(0, 99)));
               if ($urandom_range(0, 1)) r.field_hour = 8'(8'h40 | ($urandom_range(0, 1) << 5) |
                                                          bcd_pack($urandom_range(1, 12)));
               r.field_second[7] = 1'($urandom); r.field_minute[7] = 1'($urandom);
               r.field_month[7:5] = 3'($urandom); r.field_weekday[7:3] = 5'($urandom);
            end
            2, 3, 4: begin
               r = set_req($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                           $urandom_range(1, 28), $urandom_range(1, 12),
                           $urandom_range(0, 99));
               if ($urandom_range(0, 2) == 0) r.field_date = 8'($urandom_range(28, 31));
            end
            5, 6, 7: r = adjust_req($urandom_range(0, 1) ? $urandom_range(0, 255) - 128
                                                         : $urandom_range(0, 6) - 3);
            default: begin
               r = req_type'({$urandom, $urandom, $urandom});
            end
         endcase
         send_beat(r);
      end
   endtask

   task automatic test_back_pressure();
      hold_cycles = 300;
      hold_off = 1'b1;
      test_random_commands(20);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
         if (hold_cycles > 0) hold_cycles--;
         else hold_off <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 9) < 7) || (cycle_count % 500 < 100);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (expected_times.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_times.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.rtc_write !== want.rtc_write) begin
               $error("rtc_write: expected %0d, got %0d", want.rtc_write, rsp_data.rtc_write);
               error_count++;
            end
            if (rsp_data.time_valid !== want.time_valid) begin
               $error("time_valid: expected %0d, got %0d", want.time_valid,
                      rsp_data.time_valid);
               error_count++;
            end
            if (rsp_data.bcd_second !== want.bcd_second) begin
               $error("bcd_second: expected %h, got %h", want.bcd_second, rsp_data.bcd_second);
               error_count++;
            end
            if (rsp_data.bcd_minute !== want.bcd_minute) begin
               $error("bcd_minute: expected %h, got %h", want.bcd_minute, rsp_data.bcd_minute);
               error_count++;
            end
            if (rsp_data.bcd_hour !== want.bcd_hour) begin
               $error("bcd_hour: expected %h, got %h", want.bcd_hour, rsp_data.bcd_hour);
               error_count++;
            end
            if (rsp_data.weekday_out !== want.weekday_out) begin
               $error("weekday_out: expected %0d, got %0d", want.weekday_out,
                      rsp_data.weekday_out);
               error_count++;
            end
            if (rsp_data.bcd_date !== want.bcd_date) begin
               $error("bcd_date: expected %h, got %h", want.bcd_date, rsp_data.bcd_date);
               error_count++;
            end
            if (rsp_data.bcd_month !== want.bcd_month) begin
               $error("bcd_month: expected %h, got %h", want.bcd_month, rsp_data.bcd_month);
               error_count++;
            end
            if (rsp_data.bcd_year !== want.bcd_year) begin
               $error("bcd_year: expected %h, got %h", want.bcd_year, rsp_data.bcd_year);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_rtc_calendar_set_adjust: errors");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      error_count = 0;
      beats_sent  = 0;
      beats_seen  = 0;
      cycle_count = 0;
      hold_off    = 1'b0;
      hold_cycles = 0;
      cal_sec = 0; cal_min = 0; cal_hour = 0; cal_wday = 7;
      cal_date = 1; cal_month = 1; cal_year = 0; cal_ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_commands();
      test_back_pressure();
      test_random_commands(380);
      req_valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d command beats, checked %0d result beats", beats_sent, beats_seen);
      $display("covered load, set, adjust, unused command and a long result hold-off");
      if (error_count == 0 && expected_times.size() == 0) begin
         $display("tb_rtc_calendar_set_adjust: clean");
      end else begin
         $display("tb_rtc_calendar_set_adjust: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/rtc_cal_pkg.sv
hdl/rtc_cal_step.sv
hdl/rtc_calendar_set_adjust.sv
bench/tb_rtc_calendar_set_adjust.sv
